[rtl/core/wfv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfv_pkg
// Shared types, codes, reset values and fixed-point helpers of the waypoint
// follower.
// ----------------------------------------------------------------------------
package wfv_pkg;

    // default store depth
    localparam int unsigned MAX_WAYPOINTS_DEF = 1024;

    // command queue between front and back
    localparam int unsigned CMD_FIFO_DEPTH = 2;

    // item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_ODOM = 1'b1;

    // result status codes
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_FINISHED = 3'd1;
    localparam logic [2:0] ST_REACHED  = 3'd2;
    localparam logic [2:0] ST_COMMAND  = 3'd3;
    localparam logic [2:0] ST_STORED   = 3'd4;
    localparam logic [2:0] ST_IGNORED  = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_PRINT_GAIN     = 2'd0;
    localparam logic [1:0] CFG_TRAVEL_GAIN    = 2'd1;
    localparam logic [1:0] CFG_REACH_DISTANCE = 2'd2;

    // configuration reset values
    localparam logic [15:0] RST_PRINT_GAIN     = 16'd39322;
    localparam logic [15:0] RST_TRAVEL_GAIN    = 16'd39322;
    localparam logic [30:0] RST_REACH_DISTANCE = 31'd9830;

    // quaternion component limit, Q2.14 one
    localparam logic signed [15:0] QUAT_MAX = 16'sd16384;
    localparam logic signed [15:0] QUAT_MIN = -16'sd16384;

    // Q1.30 one
    localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;

    localparam logic signed [71:0] S32_MAX = 72'sd2147483647;
    localparam logic signed [71:0] S32_MIN = -72'sd2147483648;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               print_flag;
        logic               last_waypoint;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic               extrude;
        logic [10:0]        waypoint_index;
    } out_item_t;

    // classified command handed from front to back
    typedef struct packed {
        logic               kind;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               print_flag;
        logic               last_waypoint;
        logic               yaw_zero;
        logic signed [31:0] yaw_a;
        logic signed [31:0] yaw_b;
    } cmd_t;

    typedef struct packed {
        logic [15:0] print_gain;
        logic [15:0] travel_gain;
        logic [30:0] reach_distance;
    } cfg_t;

    // round(v / 2^k), half away from zero
    function automatic logic signed [71:0] rnd_shr(input logic signed [71:0] v,
                                                   input int unsigned k);
        logic [71:0] mag;
        logic [71:0] res;
        mag = v[71] ? 72'(-v) : 72'(v);
        res = (mag + (72'(1) << (k - 1))) >> k;
        return v[71] ? -$signed(res) : $signed(res);
    endfunction

    // saturate to 32-bit signed
    function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
        logic signed [31:0] res;
        if (v > S32_MAX) begin
            res = 32'sh7fffffff;
        end else if (v < S32_MIN) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

[rtl/core/wfv_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfv_front
// Accepts input transactions, clamps the quaternion and, for odometry items,
// reduces it to the yaw terms a, b and a gimbal-lock flag, then queues a command.
// ----------------------------------------------------------------------------
module wfv_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  wfv_pkg::in_item_t s_data,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output wfv_pkg::cmd_t     cmd_data
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_SQ   = 2'd1;
    localparam logic [1:0] F_XP   = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0] state_reg, state_next;

    wfv_pkg::in_item_t item_reg;
    logic signed [15:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic signed [31:0] xx_reg, yy_reg, zz_reg, ww_reg;
    logic signed [31:0] xz_reg, wy_reg, xy_reg, wz_reg;

    logic signed [31:0] n_sum, g_sum, g_mag, a_sum, b_sum;

    function automatic logic signed [15:0] clampq(input logic signed [15:0] v);
        logic signed [15:0] res;
        if (v > wfv_pkg::QUAT_MAX) begin
            res = wfv_pkg::QUAT_MAX;
        end else if (v < wfv_pkg::QUAT_MIN) begin
            res = wfv_pkg::QUAT_MIN;
        end else begin
            res = v;
        end
        return res;
    endfunction

    assign s_ready   = (state_reg == F_IDLE);
    assign cmd_valid = (state_reg == F_PUSH);

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (s_valid) begin
                    state_next = (s_data.kind == wfv_pkg::KIND_LOAD) ? F_PUSH : F_SQ;
                end
            end
            F_SQ:   state_next = F_XP;
            F_XP:   state_next = F_PUSH;
            F_PUSH: begin
                if (cmd_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // capture, clamp and quaternion products, four per cycle
    always_ff @(posedge aclk) begin
        if (state_reg == F_IDLE && s_valid) begin
            item_reg <= s_data;
            qx_reg   <= clampq(s_data.quat_x);
            qy_reg   <= clampq(s_data.quat_y);
            qz_reg   <= clampq(s_data.quat_z);
            qw_reg   <= clampq(s_data.quat_w);
        end
        if (state_reg == F_SQ) begin
            xx_reg <= qx_reg * qx_reg;
            yy_reg <= qy_reg * qy_reg;
            zz_reg <= qz_reg * qz_reg;
            ww_reg <= qw_reg * qw_reg;
        end
        if (state_reg == F_XP) begin
            xz_reg <= qx_reg * qz_reg;
            wy_reg <= qw_reg * qy_reg;
            xy_reg <= qx_reg * qy_reg;
            wz_reg <= qw_reg * qz_reg;
        end
    end

    // yaw terms
    assign n_sum = xx_reg + yy_reg + zz_reg + ww_reg;
    assign g_sum = (xz_reg - wy_reg) <<< 1;
    assign a_sum = (xy_reg + wz_reg) <<< 1;
    assign b_sum = ww_reg + xx_reg - yy_reg - zz_reg;
    assign g_mag = g_sum[31] ? -g_sum : g_sum;

    always_comb begin
        cmd_data.kind          = item_reg.kind;
        cmd_data.pos_x         = item_reg.pos_x;
        cmd_data.pos_y         = item_reg.pos_y;
        cmd_data.pos_z         = item_reg.pos_z;
        cmd_data.print_flag    = item_reg.print_flag;
        cmd_data.last_waypoint = item_reg.last_waypoint;
        cmd_data.yaw_zero      = (n_sum == 32'sd0) || (g_mag >= n_sum);
        cmd_data.yaw_a         = a_sum;
        cmd_data.yaw_b         = b_sum;
    end

endmodule

[rtl/core/wfv_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfv_fifo
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module wfv_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  wfv_pkg::cmd_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output wfv_pkg::cmd_t pop_data
);

    localparam int unsigned DEPTH = wfv_pkg::CMD_FIFO_DEPTH;
    localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned NW    = $clog2(DEPTH + 1);

    wfv_pkg::cmd_t slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0] count_reg;
    logic          do_push, do_pop;

    assign push_ready = (count_reg != NW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/core/wfv_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfv_back
// Executes commands: waypoint store, reach test, gain scaling, yaw from an
// iterative square root and divider, body-frame rotation, result register.
// ----------------------------------------------------------------------------
module wfv_back #(
    parameter int unsigned MAX_WAYPOINTS = wfv_pkg::MAX_WAYPOINTS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  wfv_pkg::cfg_t      cfg,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  wfv_pkg::cmd_t      cmd_data,
    output logic               m_valid,
    input  logic               m_ready,
    output wfv_pkg::out_item_t m_data
);

    localparam int unsigned IW = $clog2(MAX_WAYPOINTS);
    localparam int unsigned CW = $clog2(MAX_WAYPOINTS + 1);

    localparam logic [4:0] B_IDLE = 5'd0;
    localparam logic [4:0] B_DEC  = 5'd1;
    localparam logic [4:0] B_DIFF = 5'd2;
    localparam logic [4:0] B_CHK  = 5'd3;
    localparam logic [4:0] B_SQX  = 5'd4;
    localparam logic [4:0] B_SQY  = 5'd5;
    localparam logic [4:0] B_SQZ  = 5'd6;
    localparam logic [4:0] B_RSQ  = 5'd7;
    localparam logic [4:0] B_CMP  = 5'd8;
    localparam logic [4:0] B_GX   = 5'd9;
    localparam logic [4:0] B_GY   = 5'd10;
    localparam logic [4:0] B_GZ   = 5'd11;
    localparam logic [4:0] B_AA   = 5'd12;
    localparam logic [4:0] B_BB   = 5'd13;
    localparam logic [4:0] B_SQRT = 5'd14;
    localparam logic [4:0] B_DIVP = 5'd15;
    localparam logic [4:0] B_DIV  = 5'd16;
    localparam logic [4:0] B_SGN  = 5'd17;
    localparam logic [4:0] B_R1   = 5'd18;
    localparam logic [4:0] B_R2   = 5'd19;
    localparam logic [4:0] B_R3   = 5'd20;
    localparam logic [4:0] B_R4   = 5'd21;
    localparam logic [4:0] B_R5   = 5'd22;
    localparam logic [4:0] B_OUT  = 5'd23;

    typedef struct packed {
        logic               print;
        logic signed [31:0] z;
        logic signed [31:0] y;
        logic signed [31:0] x;
    } wp_t;

    logic [4:0] state_reg, state_next;

    // path state
    logic [CW-1:0] len_reg, idx_reg;
    logic          active_reg;

    // waypoint store
    wp_t wp_mem [MAX_WAYPOINTS];
    wp_t rd_ent_reg;
    wp_t wr_ent;
    logic mem_we;

    wfv_pkg::cmd_t item_reg;

    // datapath
    logic signed [32:0] dx_reg, dy_reg, dz_reg;
    logic signed [33:0] ex_reg, ey_reg;
    logic [63:0]        sq_acc_reg;
    logic [61:0]        rsq_reg;
    logic [35:0]        sq_rem_reg;
    logic [31:0]        root_reg, r_reg;
    logic [32:0]        rem_c_reg, rem_s_reg;
    logic [31:0]        low_c_reg, low_s_reg, q_c_reg, q_s_reg;
    logic signed [31:0] c_reg, s_reg;
    logic signed [65:0] rot_reg;
    logic [4:0]         cnt_reg;

    // result fields
    logic [2:0]         status_reg;
    logic signed [31:0] vx_reg, vy_reg, vz_reg;
    logic               ext_reg;

    logic               m_valid_reg;
    wfv_pkg::out_item_t m_data_reg;

    logic [32:0] mag_x, mag_y, mag_z;
    logic [31:0] mag_a, mag_b;
    logic        near;
    logic        load_ok;
    logic [15:0] gain;
    logic [30:0] sq_op;
    logic [61:0] sq_prod;
    logic signed [33:0] mop_a;
    logic signed [31:0] mop_b;
    logic signed [65:0] mprod;
    logic [35:0] sqrt_rem_n, sqrt_trial;
    logic [31:0] r_div;
    logic [63:0] num_c, num_s;
    logic [32:0] rem_c_n, rem_s_n;
    logic [31:0] cm_mag, sm_mag;
    logic        out_load;
    logic [CW+10:0] idx_wide;

    assign cmd_ready = (state_reg == B_IDLE);
    assign out_load  = (state_reg == B_OUT) && (!m_valid_reg || m_ready);
    assign load_ok   = !active_reg && (len_reg < CW'(MAX_WAYPOINTS));

    // magnitudes
    assign mag_x = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
    assign mag_y = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);
    assign mag_z = dz_reg[32] ? 33'(-dz_reg) : 33'(dz_reg);
    assign mag_a = item_reg.yaw_a[31] ? 32'(-item_reg.yaw_a) : 32'(item_reg.yaw_a);
    assign mag_b = item_reg.yaw_b[31] ? 32'(-item_reg.yaw_b) : 32'(item_reg.yaw_b);
    assign near  = (mag_x < {2'b00, cfg.reach_distance}) &&
                   (mag_y < {2'b00, cfg.reach_distance}) &&
                   (mag_z < {2'b00, cfg.reach_distance});
    assign gain  = rd_ent_reg.print ? cfg.print_gain : cfg.travel_gain;

    // shared squarer
    always_comb begin
        case (state_reg)
            B_SQX:   sq_op = mag_x[30:0];
            B_SQY:   sq_op = mag_y[30:0];
            B_SQZ:   sq_op = mag_z[30:0];
            B_RSQ:   sq_op = cfg.reach_distance;
            B_AA:    sq_op = mag_a[30:0];
            B_BB:    sq_op = mag_b[30:0];
            default: sq_op = '0;
        endcase
    end
    assign sq_prod = sq_op * sq_op;

    // shared signed multiplier
    always_comb begin
        case (state_reg)
            B_GX: begin
                mop_a = 34'(dx_reg);
                mop_b = $signed({16'b0, gain});
            end
            B_GY: begin
                mop_a = 34'(dy_reg);
                mop_b = $signed({16'b0, gain});
            end
            B_GZ: begin
                mop_a = 34'(dz_reg);
                mop_b = $signed({16'b0, gain});
            end
            B_R1: begin
                mop_a = ex_reg;
                mop_b = c_reg;
            end
            B_R2: begin
                mop_a = ey_reg;
                mop_b = s_reg;
            end
            B_R3: begin
                mop_a = ey_reg;
                mop_b = c_reg;
            end
            B_R4: begin
                mop_a = ex_reg;
                mop_b = s_reg;
            end
            default: begin
                mop_a = '0;
                mop_b = '0;
            end
        endcase
    end
    assign mprod = mop_a * mop_b;

    // square root step, one result bit per cycle
    assign sqrt_rem_n = {sq_rem_reg[33:0], sq_acc_reg[63:62]};
    assign sqrt_trial = {2'b00, root_reg, 2'b01};

    // divider setup and step
    assign r_div   = (root_reg == '0) ? 32'd1 : root_reg;
    assign num_c   = {3'b000, mag_b[30:0], 30'b0} + 64'(r_div >> 1);
    assign num_s   = {3'b000, mag_a[30:0], 30'b0} + 64'(r_div >> 1);
    assign rem_c_n = {rem_c_reg[31:0], low_c_reg[31]};
    assign rem_s_n = {rem_s_reg[31:0], low_s_reg[31]};
    assign cm_mag  = (q_c_reg > 32'(wfv_pkg::Q30_ONE)) ? 32'(wfv_pkg::Q30_ONE) : q_c_reg;
    assign sm_mag  = (q_s_reg > 32'(wfv_pkg::Q30_ONE)) ? 32'(wfv_pkg::Q30_ONE) : q_s_reg;

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: if (cmd_valid) state_next = B_DEC;
            B_DEC: begin
                if (item_reg.kind == wfv_pkg::KIND_LOAD || !active_reg ||
                    idx_reg >= len_reg) begin
                    state_next = B_OUT;
                end else begin
                    state_next = B_DIFF;
                end
            end
            B_DIFF: state_next = B_CHK;
            B_CHK:  state_next = near ? B_SQX : B_GX;
            B_SQX:  state_next = B_SQY;
            B_SQY:  state_next = B_SQZ;
            B_SQZ:  state_next = B_RSQ;
            B_RSQ:  state_next = B_CMP;
            B_CMP:  state_next = (sq_acc_reg < 64'(rsq_reg)) ? B_OUT : B_GX;
            B_GX:   state_next = B_GY;
            B_GY:   state_next = B_GZ;
            B_GZ:   state_next = item_reg.yaw_zero ? B_R1 : B_AA;
            B_AA:   state_next = B_BB;
            B_BB:   state_next = B_SQRT;
            B_SQRT: if (cnt_reg == '1) state_next = B_DIVP;
            B_DIVP: state_next = B_DIV;
            B_DIV:  if (cnt_reg == '1) state_next = B_SGN;
            B_SGN:  state_next = B_R1;
            B_R1:   state_next = B_R2;
            B_R2:   state_next = B_R3;
            B_R3:   state_next = B_R4;
            B_R4:   state_next = B_R5;
            B_R5:   state_next = B_OUT;
            B_OUT:  if (out_load) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            len_reg     <= '0;
            idx_reg     <= '0;
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == B_DEC) begin
                if (item_reg.kind == wfv_pkg::KIND_LOAD) begin
                    if (load_ok) begin
                        len_reg <= len_reg + 1'b1;
                        if (item_reg.last_waypoint) begin
                            active_reg <= 1'b1;
                            idx_reg    <= '0;
                        end
                    end
                end else if (active_reg && idx_reg >= len_reg) begin
                    active_reg <= 1'b0;
                    len_reg    <= '0;
                end
            end
            if (state_reg == B_CMP && sq_acc_reg < 64'(rsq_reg)) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // waypoint store, registered read at the current index
    assign mem_we = (state_reg == B_DEC) && (item_reg.kind == wfv_pkg::KIND_LOAD) && load_ok;
    always_comb begin
        wr_ent.print = item_reg.print_flag;
        wr_ent.x     = item_reg.pos_x;
        wr_ent.y     = item_reg.pos_y;
        wr_ent.z     = item_reg.pos_z;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            wp_mem[len_reg[IW-1:0]] <= wr_ent;
        end
        rd_ent_reg <= wp_mem[idx_reg[IW-1:0]];
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            B_IDLE: begin
                if (cmd_valid) begin
                    item_reg <= cmd_data;
                end
            end
            B_DEC: begin
                vx_reg  <= '0;
                vy_reg  <= '0;
                vz_reg  <= '0;
                ext_reg <= 1'b0;
                if (item_reg.kind == wfv_pkg::KIND_LOAD) begin
                    status_reg <= load_ok ? wfv_pkg::ST_STORED : wfv_pkg::ST_IGNORED;
                end else if (!active_reg) begin
                    status_reg <= wfv_pkg::ST_IDLE;
                end else if (idx_reg >= len_reg) begin
                    status_reg <= wfv_pkg::ST_FINISHED;
                end
            end
            B_DIFF: begin
                dx_reg <= 33'(rd_ent_reg.x) - 33'(item_reg.pos_x);
                dy_reg <= 33'(rd_ent_reg.y) - 33'(item_reg.pos_y);
                dz_reg <= 33'(rd_ent_reg.z) - 33'(item_reg.pos_z);
            end
            B_SQX: sq_acc_reg <= 64'(sq_prod);
            B_SQY: sq_acc_reg <= sq_acc_reg + 64'(sq_prod);
            B_SQZ: sq_acc_reg <= sq_acc_reg + 64'(sq_prod);
            B_RSQ: rsq_reg    <= sq_prod;
            B_CMP: status_reg <= wfv_pkg::ST_REACHED;
            B_GX: begin
                ext_reg <= rd_ent_reg.print;
                ex_reg  <= 34'(wfv_pkg::rnd_shr(72'(mprod), 16));
                c_reg   <= wfv_pkg::Q30_ONE;
                s_reg   <= '0;
            end
            B_GY: ey_reg <= 34'(wfv_pkg::rnd_shr(72'(mprod), 16));
            B_GZ: vz_reg <= wfv_pkg::sat32(wfv_pkg::rnd_shr(72'(mprod), 16));
            B_AA: sq_acc_reg <= 64'(sq_prod);
            B_BB: begin
                sq_acc_reg <= sq_acc_reg + 64'(sq_prod);
                sq_rem_reg <= '0;
                root_reg   <= '0;
                cnt_reg    <= '0;
            end
            B_SQRT: begin
                sq_acc_reg <= sq_acc_reg << 2;
                cnt_reg    <= cnt_reg + 1'b1;
                if (sqrt_rem_n >= sqrt_trial) begin
                    sq_rem_reg <= sqrt_rem_n - sqrt_trial;
                    root_reg   <= {root_reg[30:0], 1'b1};
                end else begin
                    sq_rem_reg <= sqrt_rem_n;
                    root_reg   <= {root_reg[30:0], 1'b0};
                end
            end
            B_DIVP: begin
                r_reg     <= r_div;
                rem_c_reg <= {1'b0, num_c[63:32]};
                rem_s_reg <= {1'b0, num_s[63:32]};
                low_c_reg <= num_c[31:0];
                low_s_reg <= num_s[31:0];
                cnt_reg   <= '0;
            end
            B_DIV: begin
                cnt_reg   <= cnt_reg + 1'b1;
                low_c_reg <= low_c_reg << 1;
                low_s_reg <= low_s_reg << 1;
                if (rem_c_n >= {1'b0, r_reg}) begin
                    rem_c_reg <= rem_c_n - {1'b0, r_reg};
                    q_c_reg   <= {q_c_reg[30:0], 1'b1};
                end else begin
                    rem_c_reg <= rem_c_n;
                    q_c_reg   <= {q_c_reg[30:0], 1'b0};
                end
                if (rem_s_n >= {1'b0, r_reg}) begin
                    rem_s_reg <= rem_s_n - {1'b0, r_reg};
                    q_s_reg   <= {q_s_reg[30:0], 1'b1};
                end else begin
                    rem_s_reg <= rem_s_n;
                    q_s_reg   <= {q_s_reg[30:0], 1'b0};
                end
            end
            B_SGN: begin
                c_reg <= item_reg.yaw_b[31] ? -$signed(cm_mag) : $signed(cm_mag);
                s_reg <= item_reg.yaw_a[31] ? -$signed(sm_mag) : $signed(sm_mag);
            end
            B_R1: rot_reg <= mprod;
            B_R2: rot_reg <= rot_reg + mprod;
            B_R3: begin
                vx_reg  <= wfv_pkg::sat32(wfv_pkg::rnd_shr(72'(rot_reg), 30));
                rot_reg <= mprod;
            end
            B_R4: rot_reg <= rot_reg - mprod;
            B_R5: begin
                vy_reg     <= wfv_pkg::sat32(wfv_pkg::rnd_shr(72'(rot_reg), 30));
                status_reg <= wfv_pkg::ST_COMMAND;
            end
            default: begin
            end
        endcase
    end

    // result register
    assign idx_wide = (CW + 11)'(idx_reg);
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.status         <= status_reg;
            m_data_reg.vel_x          <= vx_reg;
            m_data_reg.vel_y          <= vy_reg;
            m_data_reg.vel_z          <= vz_reg;
            m_data_reg.extrude        <= ext_reg;
            m_data_reg.waypoint_index <= idx_wide[10:0];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[rtl/core/waypoint_follower_velocity.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_follower_velocity
// Proportional waypoint follower: stores a path and turns odometry into
// saturated body-frame velocity commands.
// ----------------------------------------------------------------------------
//  channel  | ports                          | transaction
//  ---------+--------------------------------+----------------------------
//  input    | s_valid s_ready s_data         | load or odometry item
//  result   | m_valid m_ready m_data         | one result per input item
//  config   | cfg_we cfg_index cfg_wdata     | register write, no wait
//
//  The front takes one item at a time into a two-entry queue. The back
//  answers load, idle and finished items without the datapath, tests reach
//  for odometry, and for a command with nonzero yaw runs the 32-step square
//  root and the 32-step divider that forms both yaw quotients.
//  Synchronous active-low reset; the waypoint store needs no clearing.
//  A stalled result register holds the back; the front keeps filling the queue.
// ----------------------------------------------------------------------------
module waypoint_follower_velocity #(
    parameter int unsigned MAX_WAYPOINTS = wfv_pkg::MAX_WAYPOINTS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  wfv_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output wfv_pkg::out_item_t m_data,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [30:0]        cfg_wdata
);

    wfv_pkg::cfg_t cfg_reg;
    logic          f_valid, f_ready, b_valid, b_ready;
    wfv_pkg::cmd_t f_data, b_data;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.print_gain     <= wfv_pkg::RST_PRINT_GAIN;
            cfg_reg.travel_gain    <= wfv_pkg::RST_TRAVEL_GAIN;
            cfg_reg.reach_distance <= wfv_pkg::RST_REACH_DISTANCE;
        end else if (cfg_we) begin
            unique case (cfg_index)
                wfv_pkg::CFG_PRINT_GAIN:     cfg_reg.print_gain     <= cfg_wdata[15:0];
                wfv_pkg::CFG_TRAVEL_GAIN:    cfg_reg.travel_gain    <= cfg_wdata[15:0];
                wfv_pkg::CFG_REACH_DISTANCE: cfg_reg.reach_distance <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    wfv_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd_data  (f_data)
    );

    wfv_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_data),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_data)
    );

    wfv_back #(
        .MAX_WAYPOINTS (MAX_WAYPOINTS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd_valid (b_valid),
        .cmd_ready (b_ready),
        .cmd_data  (b_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

`ifndef SYNTH
    // velocity and extrude are zero outside command results
    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != wfv_pkg::ST_COMMAND |->
        m_data.vel_x == 0 && m_data.vel_y == 0 && m_data.vel_z == 0 && !m_data.extrude)
        else $error("nonzero payload on non-command result");

    // front holds one transaction at a time
    a_front_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("front accepted back-to-back transactions");

    // a waiting result stays put until taken
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");
`endif

endmodule
